FILE: sv/hsv2rgb_pkg.sv
// Shared constants, sector codes and a helper for the HSV to RGBA converter.
package hsv2rgb_pkg;

	localparam int HUE_BITS_DEF = 16;
	localparam int CH_W = 8;
	localparam int SEC_W = 3;

	localparam logic [CH_W-1:0] K_FULL = 8'd255;

	localparam logic [SEC_W-1:0] SEC_RED_YEL = 3'd0;
	localparam logic [SEC_W-1:0] SEC_YEL_GRN = 3'd1;
	localparam logic [SEC_W-1:0] SEC_GRN_CYN = 3'd2;
	localparam logic [SEC_W-1:0] SEC_CYN_BLU = 3'd3;
	localparam logic [SEC_W-1:0] SEC_BLU_MAG = 3'd4;

	// floor(y / 255), exact for y <= 255 * 255
	function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] y);
		logic [2*CH_W:0] sum;
		sum = {1'b0, y} + {9'd0, y[2*CH_W-1:CH_W]} + 17'd1;
		return sum[2*CH_W-1:CH_W];
	endfunction

endpackage

FILE: sv/hsv_to_rgba_converter.sv
// HSV-plus-alpha to 8-bit RGBA pixel converter, five-stage pipeline.
// Throughput: one pixel per cycle while out_ready holds; set by the per-stage valid/ready chain.
// A stall at the output backs up stage by stage, bubbles are filled first.
// Reset clears all stage valid bits; datapath registers are not reset.
module hsv_to_rgba_converter
	import hsv2rgb_pkg::*;
#(
	parameter int HUE_BITS = HUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [HUE_BITS-1:0] hue_angle,
	input  logic [CH_W-1:0]     saturation,
	input  logic [CH_W-1:0]     brightness,
	input  logic [CH_W-1:0]     opacity,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CH_W-1:0]     red,
	output logic [CH_W-1:0]     green,
	output logic [CH_W-1:0]     blue,
	output logic [CH_W-1:0]     alpha_out
);

	localparam int H6_W = HUE_BITS + SEC_W;
	localparam int X_W = HUE_BITS + CH_W;
	localparam int M_W = HUE_BITS + 2 * CH_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic [SEC_W-1:0]    sec_s1, sec_s2, sec_s3, sec_s4;
	logic [HUE_BITS-1:0] frac_s1;
	logic [CH_W-1:0]     sat_s1, sat_s2, sat_s3, sat_s4;
	logic [CH_W-1:0]     val_s1, val_s2, val_s3, val_s4;
	logic [CH_W-1:0]     alp_s1, alp_s2, alp_s3, alp_s4;
	logic [X_W-1:0]      xq_s2;
	logic [2*CH_W-1:0]   pn_s2, pn_s3, pn_s4;
	logic [X_W-1:0]      dq_s3, dt_s3;
	logic [2*CH_W-1:0]   mq_s4, mt_s4;
	logic [CH_W-1:0]     red_s5, green_s5, blue_s5, alpha_s5;

	logic [H6_W-1:0]   h6;
	logic [X_W-1:0]    sat_sh, d_full;
	logic [M_W-1:0]    mq_full, mt_full;
	logic [CH_W-1:0]   p_val, q_val, t_val;

	assign en5 = !v_s5 || out_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// hue * 6 splits into sector and fraction
	assign h6 = ({{SEC_W{1'b0}}, hue_angle} << 2) + ({{SEC_W{1'b0}}, hue_angle} << 1);

	always_ff @(posedge clk) begin
		if (en1) begin
			sec_s1  <= h6[H6_W-1:HUE_BITS];
			frac_s1 <= h6[HUE_BITS-1:0];
			sat_s1  <= saturation;
			val_s1  <= brightness;
			alp_s1  <= opacity;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			sec_s2 <= sec_s1;
			sat_s2 <= sat_s1;
			val_s2 <= val_s1;
			alp_s2 <= alp_s1;
			xq_s2  <= {{HUE_BITS{1'b0}}, sat_s1} * {{CH_W{1'b0}}, frac_s1};
			pn_s2  <= {{CH_W{1'b0}}, val_s1} * {{CH_W{1'b0}}, 8'(K_FULL - sat_s1)};
		end
	end

	assign sat_sh = {sat_s2, {HUE_BITS{1'b0}}};
	assign d_full = {K_FULL, {HUE_BITS{1'b0}}};

	always_ff @(posedge clk) begin
		if (en3) begin
			sec_s3 <= sec_s2;
			sat_s3 <= sat_s2;
			val_s3 <= val_s2;
			alp_s3 <= alp_s2;
			pn_s3  <= pn_s2;
			dq_s3  <= d_full - xq_s2;
			dt_s3  <= d_full - (sat_sh - xq_s2);
		end
	end

	assign mq_full = {{(M_W-CH_W){1'b0}}, val_s3} * {{CH_W{1'b0}}, dq_s3};
	assign mt_full = {{(M_W-CH_W){1'b0}}, val_s3} * {{CH_W{1'b0}}, dt_s3};

	always_ff @(posedge clk) begin
		if (en4) begin
			sec_s4 <= sec_s3;
			sat_s4 <= sat_s3;
			val_s4 <= val_s3;
			alp_s4 <= alp_s3;
			pn_s4  <= pn_s3;
			mq_s4  <= mq_full[M_W-1:HUE_BITS];
			mt_s4  <= mt_full[M_W-1:HUE_BITS];
		end
	end

	assign p_val = div255(pn_s4);
	assign q_val = div255(mq_s4);
	assign t_val = div255(mt_s4);

	always_ff @(posedge clk) begin
		if (en5) begin
			alpha_s5 <= alp_s4;
			case (sec_s4)
				SEC_RED_YEL: begin
					red_s5 <= val_s4; green_s5 <= t_val;  blue_s5 <= p_val;
				end
				SEC_YEL_GRN: begin
					red_s5 <= q_val;  green_s5 <= val_s4; blue_s5 <= p_val;
				end
				SEC_GRN_CYN: begin
					red_s5 <= p_val;  green_s5 <= val_s4; blue_s5 <= t_val;
				end
				SEC_CYN_BLU: begin
					red_s5 <= p_val;  green_s5 <= q_val;  blue_s5 <= val_s4;
				end
				SEC_BLU_MAG: begin
					red_s5 <= t_val;  green_s5 <= p_val;  blue_s5 <= val_s4;
				end
				default: begin
					red_s5 <= val_s4; green_s5 <= p_val;  blue_s5 <= q_val;
				end
			endcase
		end
	end

	assign out_valid = v_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;
	assign alpha_out = alpha_s5;

	// input is only refused when every stage holds a request
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5))
		else $error("input blocked while pipeline has a bubble");

	// zero saturation gives a grey pixel
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && sat_s4 == '0) |-> (mq_s4 == pn_s4 && mt_s4 == pn_s4))
		else $error("p, q, t differ at zero saturation");

	// a stalled stage-4 request keeps its products
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !en4) |=> ($stable(mq_s4) && $stable(mt_s4) && $stable(sec_s4)))
		else $error("stage 4 changed while stalled");

endmodule
